FILE: src/gnidf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gnidf_pkg;
    localparam int unsigned MaxPanelsDef = 256;
    localparam int unsigned MaxGridSideDef = 1024;
    localparam logic [30:0] SpacingReset = 31'd65536;
    localparam int unsigned GridMargin = 5;

    typedef struct packed {
        logic [31:0] mid_x;
        logic [31:0] mid_y;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic        action;
    } t_in_item;

    typedef struct packed {
        logic [31:0] node_x;
        logic [31:0] node_y;
        logic [31:0] distance;
        logic        inside_res;
        logic [7:0]  nearest_panel;
        logic        last_node;
        logic        status;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_GRID  = 2'd2,
        CMD_NODE  = 2'd3
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        logic    scan_step;
        logic    scan_first;
        logic    sqrt_start;
        logic    sqrt_step;
        logic    advance;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic scan_last;
        logic sqrt_done;
        logic walk_done;
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

FILE: src/gnidf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gnidf_in_if;
    logic                valid;
    logic                ready;
    gnidf_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gnidf_out_if;
    logic                 valid;
    logic                 ready;
    gnidf_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/gnidf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gnidf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_action,
    output logic               o_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_err,
    output logic               o_done_res,
    output gnidf_pkg::t_cmd    o_cmd,
    input  wire gnidf_pkg::t_stat i_stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_GRID, S_SCAN, S_MUL, S_SQRT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid, r_err, r_done_res, r_have_grid, r_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_err <= 1'b0;
            r_done_res <= 1'b0;
            r_have_grid <= 1'b0;
            r_mul <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        if (!i_action) begin
                            // a load into a full store leaves the walk alone
                            if (!i_stat.full) r_have_grid <= 1'b0;
                        end else if (i_stat.empty) begin
                            r_err <= 1'b1; r_done_res <= 1'b0;
                            r_state <= S_OUT;
                        end else if (r_have_grid && i_stat.walk_done) begin
                            r_err <= 1'b0; r_done_res <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_err <= 1'b0; r_done_res <= 1'b0;
                            r_state <= r_have_grid ? S_SCAN : S_GRID;
                        end
                    end
                end
                S_GRID: begin
                    if (i_stat.div_done) begin
                        r_have_grid <= 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_last) begin
                        r_state <= S_MUL;
                        r_mul <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_mul <= 1'b1;
                    if (r_mul) r_state <= S_SQRT;
                end
                S_SQRT: if (i_stat.sqrt_done) r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_ready = (r_state == S_IDLE) && !r_out_valid;
        o_cmd = '0;
        o_cmd.op = gnidf_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    if (!i_action) o_cmd.op = gnidf_pkg::CMD_LOAD;
                    else if (!i_stat.empty && !r_have_grid) o_cmd.op = gnidf_pkg::CMD_GRID;
                    o_cmd.scan_first = i_action;
                end
            end
            S_SCAN: o_cmd.scan_step = 1'b1;
            S_MUL: o_cmd.sqrt_start = r_mul;
            S_SQRT: o_cmd.sqrt_step = 1'b1;
            S_OUT: begin
                o_cmd.op = gnidf_pkg::CMD_NODE;
                o_cmd.advance = !r_out_valid && !r_err && !r_done_res;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_err = r_err;
    assign o_done_res = r_done_res;
endmodule
`default_nettype wire

FILE: src/gnidf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module gnidf_dpath #(
    parameter int unsigned MAX_PANELS = gnidf_pkg::MaxPanelsDef,
    parameter int unsigned MAX_GRID_SIDE = gnidf_pkg::MaxGridSideDef
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gnidf_pkg::t_in_item  i_item,
    input  wire logic [30:0]          i_spacing,
    input  wire gnidf_pkg::t_cmd      i_cmd,
    input  wire logic                 i_err,
    input  wire logic                 i_done_res,
    output gnidf_pkg::t_stat          o_stat,
    output gnidf_pkg::t_out_item      o_res
);
    localparam int PW = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
    localparam int CW = $clog2(MAX_PANELS + 1);
    localparam int GW = $clog2(MAX_GRID_SIDE + 1);

    logic [31:0] r_mx [MAX_PANELS];
    logic [31:0] r_my [MAX_PANELS];
    logic [31:0] r_nx [MAX_PANELS];
    logic [31:0] r_ny [MAX_PANELS];
    logic [CW-1:0] r_count;
    logic signed [31:0] r_maxx, r_maxy, r_minx, r_miny;
    logic [GW-1:0] r_cols, r_rows, r_col, r_row;
    logic r_walk_done;
    logic [31:0] s_val;
    assign s_val = (i_spacing == '0) ? 32'd1 : {1'b0, i_spacing};

    // side division: restoring, one quotient bit a cycle for both axes
    logic [32:0] r_ex, r_ey, r_qx, r_qy, r_rx, r_ry;
    logic [5:0]  r_dcnt;
    logic        r_div_run, r_div_done;
    logic [33:0] n_rx, n_ry;

    always_comb begin
        n_rx = {r_rx, r_ex[32]};
        n_ry = {r_ry, r_ey[32]};
    end

    function automatic logic [GW-1:0] side_f(input logic [32:0] q, input logic [32:0] r);
        logic [34:0] n;
        n = 35'(q) + 35'(r != '0) + 35'(gnidf_pkg::GridMargin);
        if (n > 35'(MAX_GRID_SIDE)) n = 35'(MAX_GRID_SIDE);
        return GW'(n);
    endfunction

    // node position
    logic signed [33:0] r_ox, r_oy;
    logic signed [31:0] r_x, r_y;
    function automatic logic signed [31:0] pos_f(input logic signed [33:0] o,
            input logic [GW-1:0] k, input logic [GW-1:0] n, input logic [31:0] s);
        logic signed [GW+2:0] m;
        logic signed [GW+35:0] v;
        logic signed [GW+35:0] h;
        m = $signed({2'b00, k, 1'b1}) - $signed({3'b000, n});
        v = (GW+36)'(o) + (GW+36)'(m) * $signed({1'b0, s});
        h = v >>> 1;
        if (h > (GW+36)'(64'sh7FFFFFFF)) h = (GW+36)'(64'sh7FFFFFFF);
        else if (h < -(GW+36)'(64'sh80000000)) h = -(GW+36)'(64'sh80000000);
        return h[31:0];
    endfunction

    // scan
    logic [CW-1:0] r_idx;
    logic [PW-1:0] r_best;
    logic [64:0]   r_best_d;
    logic signed [31:0] r_rmx, r_rmy;
    logic          r_rd_v;
    logic [PW-1:0] r_rd_i;
    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay;
    logic [64:0] dsq;
    always_comb begin
        dx = 33'(r_x) - 33'(r_rmx);
        dy = 33'(r_y) - 33'(r_rmy);
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        dsq = 65'(ax * ax) + 65'(ay * ay);
    end
    logic scan_end;
    assign scan_end = (r_idx >= r_count) || (32'(r_idx) >= MAX_PANELS);

    // inside test products and sqrt
    logic signed [31:0] r_bnx, r_bny, r_bmx, r_bmy;
    logic signed [65:0] r_p1, r_p2;
    logic [63:0] r_sv, r_sr, r_sb;
    logic r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_maxx <= '0; r_maxy <= '0; r_minx <= '0; r_miny <= '0;
            r_div_run <= 1'b0; r_div_done <= 1'b0;
            r_col <= '0; r_row <= '0; r_cols <= '0; r_rows <= '0;
            r_walk_done <= 1'b0; r_rd_v <= 1'b0;
        end else begin
            r_div_done <= (i_cmd.op != gnidf_pkg::CMD_GRID) && r_div_run && (r_dcnt == 6'd32);
            r_rd_v <= !i_cmd.scan_first && i_cmd.scan_step && !scan_end;
            if (i_cmd.op == gnidf_pkg::CMD_LOAD && 32'(r_count) < MAX_PANELS) begin
                r_mx[PW'(r_count)] <= i_item.mid_x;
                r_my[PW'(r_count)] <= i_item.mid_y;
                r_nx[PW'(r_count)] <= i_item.normal_x;
                r_ny[PW'(r_count)] <= i_item.normal_y;
                r_count <= r_count + 1'b1;
                if ($signed(i_item.mid_x) > r_maxx) r_maxx <= i_item.mid_x;
                if ($signed(i_item.mid_y) > r_maxy) r_maxy <= i_item.mid_y;
                if ($signed(i_item.mid_x) < r_minx) r_minx <= i_item.mid_x;
                if ($signed(i_item.mid_y) < r_miny) r_miny <= i_item.mid_y;
            end
            if (i_cmd.op == gnidf_pkg::CMD_GRID) begin
                r_ex <= 33'(34'(r_maxx) - 34'(r_minx));
                r_ey <= 33'(34'(r_maxy) - 34'(r_miny));
                r_ox <= 34'(r_maxx) + 34'(r_minx);
                r_oy <= 34'(r_maxy) + 34'(r_miny);
                r_rx <= '0; r_ry <= '0; r_dcnt <= '0;
                r_div_run <= 1'b1;
                r_col <= '0; r_row <= '0; r_walk_done <= 1'b0;
            end else if (r_div_run) begin
                r_ex <= {r_ex[31:0], 1'b0};
                r_ey <= {r_ey[31:0], 1'b0};
                if (n_rx >= 34'(s_val)) begin
                    r_rx <= 33'(n_rx - 34'(s_val)); r_qx <= {r_qx[31:0], 1'b1};
                end else begin
                    r_rx <= 33'(n_rx); r_qx <= {r_qx[31:0], 1'b0};
                end
                if (n_ry >= 34'(s_val)) begin
                    r_ry <= 33'(n_ry - 34'(s_val)); r_qy <= {r_qy[31:0], 1'b1};
                end else begin
                    r_ry <= 33'(n_ry); r_qy <= {r_qy[31:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == 6'd32) r_div_run <= 1'b0;
            end
            if (r_div_done) begin
                r_cols <= side_f(r_qx, r_rx);
                r_rows <= side_f(r_qy, r_ry);
            end
            if (i_cmd.advance) begin
                if (32'(r_col) + 1 >= 32'(r_cols) && 32'(r_row) + 1 >= 32'(r_rows))
                    r_walk_done <= 1'b1;
                else if (32'(r_col) + 1 >= 32'(r_cols)) begin
                    r_col <= '0; r_row <= r_row + 1'b1;
                end else r_col <= r_col + 1'b1;
            end
            if (i_cmd.scan_first) r_idx <= '0;
            else if (i_cmd.scan_step && !scan_end) r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_first) r_best_d <= '1;
        if (i_cmd.scan_step) begin
            r_x <= pos_f(r_ox, r_col, r_cols, s_val);
            r_y <= pos_f(r_oy, r_row, r_rows, s_val);
        end
        if (i_cmd.scan_step && !scan_end) begin
            r_rmx <= r_mx[PW'(r_idx)];
            r_rmy <= r_my[PW'(r_idx)];
            r_rd_i <= PW'(r_idx);
        end
        if (r_rd_v && (r_rd_i == '0 || dsq < r_best_d)) begin
            r_best_d <= dsq;
            r_best <= r_rd_i;
        end
        if (i_cmd.scan_step && scan_end && !r_rd_v) begin
            r_bnx <= r_nx[r_best]; r_bny <= r_ny[r_best];
            r_bmx <= r_mx[r_best]; r_bmy <= r_my[r_best];
        end
        r_p1 <= 66'(r_bnx) * 66'(33'(r_x) - 33'(r_bmx));
        r_p2 <= 66'(r_bny) * 66'(33'(r_y) - 33'(r_bmy));
        if (i_cmd.sqrt_start) begin
            r_sat <= r_best_d[64];
            r_sv <= r_best_d[63:0];
            r_sr <= '0;
            r_sb <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sqrt_step && r_sb != '0) begin
            if (r_sv >= r_sr + r_sb) begin
                r_sv <= r_sv - (r_sr + r_sb);
                r_sr <= (r_sr >> 1) + r_sb;
            end else r_sr <= r_sr >> 1;
            r_sb <= r_sb >> 2;
        end
    end

    logic ok;
    assign ok = !i_err && !i_done_res;
    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full = (32'(r_count) >= MAX_PANELS);
        o_stat.scan_last = scan_end && !r_rd_v;
        o_stat.sqrt_done = (r_sb == '0);
        o_stat.walk_done = r_walk_done;
        o_stat.div_done = r_div_done;
        o_res.node_x = ok ? r_x : '0;
        o_res.node_y = ok ? r_y : '0;
        o_res.distance = !ok ? '0 : (r_sat || r_sr[63:32] != '0) ? 32'hFFFF_FFFF : r_sr[31:0];
        o_res.inside_res = ok && !($signed(67'(r_p1)) > -$signed(67'(r_p2)));
        o_res.nearest_panel = ok ? 8'(32'(r_best)) : '0;
        // the walk has already advanced when the result shows; done marks the final node
        o_res.last_node = i_done_res || (ok && r_walk_done);
        o_res.status = i_err;
    end
endmodule
`default_nettype wire

FILE: src/grid_node_inside_domain_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Grid node inside-domain filter.
// Input channel: each transfer either loads one panel (action 0; midpoint and
// outward normal, Q16.16) or visits the next grid node (action 1). Loads give
// no result; every visit gives exactly one result transfer on the output.
// The first visit after a stored load, or after a spacing write made while
// idle, rebuilds the grid: a 33-step bit-serial divider sizes both sides.
// Each visit then scans every loaded panel, one panel a cycle from the panel
// stores, multiplies out the inside test, and runs a 32-step square root.
// A spacing write holds the input off while its registered flag is set.
// Visits with no panels, or after the walk ends, skip the grid, scan and
// square root and go straight to the output state.
// Reset clears the panel count, the box, the walk and the spacing (to 1.0);
// the panel stores are not cleared and need no clearing pass.
// The result is held in the output register while the receiver stalls;
// the next input transfer is taken only after it has gone.
module grid_node_inside_domain_filter #(
    parameter int unsigned MAX_PANELS = gnidf_pkg::MaxPanelsDef,
    parameter int unsigned MAX_GRID_SIDE = gnidf_pkg::MaxGridSideDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_data,
    gnidf_in_if.sink         in_ch,
    gnidf_out_if.source      out_ch
);
    logic [30:0] r_spacing;
    logic        ctrl_ready, out_valid, err, done_res;
    gnidf_pkg::t_cmd  cmd, n_cmd;
    gnidf_pkg::t_stat stat, ctrl_stat;
    gnidf_pkg::t_out_item res;
    logic        r_cfg_hit;

    // a spacing write while idle drops the grid: fold it in as a load-free reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= gnidf_pkg::SpacingReset;
            r_cfg_hit <= 1'b0;
        end else begin
            if (i_cfg_we) r_spacing <= i_cfg_data;
            r_cfg_hit <= i_cfg_we;
        end
    end

    // a spacing write while idle drops the grid, even with a full store
    always_comb begin
        ctrl_stat = stat;
        if (r_cfg_hit) ctrl_stat.full = 1'b0;
    end

    gnidf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_ch.valid || r_cfg_hit),
        .i_action   (in_ch.payload.action && !r_cfg_hit),
        .o_ready    (ctrl_ready),
        .o_out_valid(out_valid),
        .i_out_ready(out_ch.ready),
        .o_err      (err),
        .o_done_res (done_res),
        .o_cmd      (n_cmd),
        .i_stat     (ctrl_stat)
    );

    always_comb begin
        cmd = n_cmd;
        if (r_cfg_hit && cmd.op == gnidf_pkg::CMD_LOAD) cmd.op = gnidf_pkg::CMD_NONE;
    end

    gnidf_dpath #(.MAX_PANELS(MAX_PANELS), .MAX_GRID_SIDE(MAX_GRID_SIDE)) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (in_ch.payload),
        .i_spacing (r_spacing),
        .i_cmd     (cmd),
        .i_err     (err),
        .i_done_res(done_res),
        .o_stat    (stat),
        .o_res     (res)
    );

    assign in_ch.ready = ctrl_ready && !r_cfg_hit;
    assign out_ch.valid = out_valid;
    assign out_ch.payload = res;
endmodule
`default_nettype wire

FILE: sim/grid_node_inside_domain_filter_tb.sv
`timescale 1ns / 1ps
module grid_node_inside_domain_filter_tb;

    localparam int unsigned PanelDepth = gnidf_pkg::MaxPanelsDef;
    localparam int unsigned SideLimit = gnidf_pkg::MaxGridSideDef;
    // Worst quiet stretch: grid rebuild plus a full panel scan plus stalls.
    localparam int unsigned QuietLimit = 20000;
    // Settle time before a spacing write and at the end.
    localparam int unsigned SettleCycles = 400;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_VISIT = 1'b1;

    typedef enum logic [1:0] {WALK_IDLE, WALK_RUN, WALK_DONE} t_walk_phase;

    typedef struct {
        gnidf_pkg::t_in_item  item;
        bit                   typed;
        gnidf_pkg::t_out_item want;
    } t_table_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_data = '0;

    gnidf_in_if  in_ch();
    gnidf_out_if out_ch();

    grid_node_inside_domain_filter dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
    end

    // Shadow state of the block
    logic signed [31:0] mid_x_mem [PanelDepth];
    logic signed [31:0] mid_y_mem [PanelDepth];
    logic signed [31:0] nrm_x_mem [PanelDepth];
    logic signed [31:0] nrm_y_mem [PanelDepth];
    int unsigned        panels_held;
    logic signed [31:0] box_max_x, box_max_y, box_min_x, box_min_y;
    longint             cols, rows, origin_x, origin_y, walk_col, walk_row;
    t_walk_phase        walk;
    logic [30:0]        spacing;

    gnidf_pkg::t_out_item node_expect_q[$];
    int unsigned mismatches = 0;
    bit calm = 1'b0;   // no idling on either side while set

    function automatic longint spacing_eff();
        return (spacing == 0) ? 64'd1 : longint'(spacing);
    endfunction

    function automatic longint grid_side(logic signed [31:0] hi, logic signed [31:0] lo);
        longint ext, s, n;
        ext = longint'(hi) - longint'(lo);
        s = spacing_eff();
        n = 5 + (ext + s - 1) / s;
        return (n > SideLimit) ? longint'(SideLimit) : n;
    endfunction

    function automatic logic signed [31:0] node_at(longint sum, longint k, longint n);
        longint v, h;
        v = sum + (2 * k + 1 - n) * spacing_eff();
        h = v >>> 1;   // floor halve
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[31:0];
    endfunction

    function automatic logic [31:0] root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // Advance the shadow state by one input transfer; report any node result.
    task automatic predict_transfer(input gnidf_pkg::t_in_item it, output bit has_res,
                                    output gnidf_pkg::t_out_item res);
        logic signed [31:0] x, y, mx, my;
        longint             dx, dy;
        logic [63:0]        ax, ay;
        logic [64:0]        d2, best_d2;
        logic signed [65:0] dot;
        int unsigned        best;
        bit                 last;
        res = '0;
        has_res = 1'b0;
        if (it.action == ACT_LOAD) begin
            if (panels_held >= PanelDepth) return;   // store full: drop
            mx = it.mid_x;
            my = it.mid_y;
            mid_x_mem[panels_held] = mx;
            mid_y_mem[panels_held] = my;
            nrm_x_mem[panels_held] = it.normal_x;
            nrm_y_mem[panels_held] = it.normal_y;
            panels_held++;
            if (mx > box_max_x) box_max_x = mx;
            if (my > box_max_y) box_max_y = my;
            if (mx < box_min_x) box_min_x = mx;
            if (my < box_min_y) box_min_y = my;
            walk = WALK_IDLE;
            return;
        end
        has_res = 1'b1;
        if (panels_held == 0) begin
            res.status = 1'b1;
            return;
        end
        if (walk == WALK_DONE) begin
            res.last_node = 1'b1;
            return;
        end
        if (walk == WALK_IDLE) begin
            cols = grid_side(box_max_x, box_min_x);
            rows = grid_side(box_max_y, box_min_y);
            origin_x = longint'(box_max_x) + longint'(box_min_x);
            origin_y = longint'(box_max_y) + longint'(box_min_y);
            walk_col = 0;
            walk_row = 0;
            walk = WALK_RUN;
        end
        x = node_at(origin_x, walk_col, cols);
        y = node_at(origin_y, walk_row, rows);
        best = 0;
        best_d2 = '0;
        for (int unsigned i = 0; i < panels_held; i++) begin
            dx = longint'(x) - longint'(mid_x_mem[i]);
            dy = longint'(y) - longint'(mid_y_mem[i]);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            d2 = 65'(ax) * 65'(ax) + 65'(ay) * 65'(ay);
            if (i == 0 || d2 < best_d2) begin
                best = i;
                best_d2 = d2;
            end
        end
        res.distance = best_d2[64] ? 32'hFFFF_FFFF : root_floor(best_d2[63:0]);
        dx = longint'(x) - longint'(mid_x_mem[best]);
        dy = longint'(y) - longint'(mid_y_mem[best]);
        dot = nrm_x_mem[best] * dx + nrm_y_mem[best] * dy;
        res.inside_res = !(dot > 0);
        last = (walk_col + 1 >= cols) && (walk_row + 1 >= rows);
        if (last) begin
            walk = WALK_DONE;
        end else if (walk_col + 1 >= cols) begin
            walk_col = 0;
            walk_row++;
        end else begin
            walk_col++;
        end
        res.node_x = x;
        res.node_y = y;
        res.nearest_panel = best[7:0];
        res.last_node = last;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 26);
    endfunction

    // Present one item, hold it until the transfer, then predict.
    task automatic send_item(input gnidf_pkg::t_in_item it, input bit typed,
                             input gnidf_pkg::t_out_item want);
        bit                   has_res;
        gnidf_pkg::t_out_item res;
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_transfer(it, has_res, res);
        if (has_res) node_expect_q.push_back(typed ? want : res);
    endtask

    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (node_expect_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_spacing(input logic [30:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        spacing = v;
        walk = WALK_IDLE;
    endtask

    function automatic gnidf_pkg::t_in_item visit_item();
        gnidf_pkg::t_in_item it;
        it = {$urandom, $urandom, $urandom, $urandom, ACT_VISIT};   // panel fields are noise
        return it;
    endfunction

    function automatic gnidf_pkg::t_in_item panel_item(logic [31:0] mx, logic [31:0] my,
                                                       logic [31:0] nx, logic [31:0] ny);
        gnidf_pkg::t_in_item it;
        it.action = ACT_LOAD;
        it.mid_x = mx;
        it.mid_y = my;
        it.normal_x = nx;
        it.normal_y = ny;
        return it;
    endfunction

    function automatic gnidf_pkg::t_in_item random_item();
        logic [31:0] mx, my;
        if ($urandom_range(0, 99) < 88) return visit_item();
        if ($urandom_range(0, 1)) begin
            // Keep half of the midpoints compact so that walks can finish
            mx = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            my = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end else begin
            mx = $urandom;
            my = $urandom;
        end
        return panel_item(mx, my, $urandom, $urandom);
    endfunction

    // Output side: random stalls, compare each transfer with the oldest expectation.
    int unsigned quiet = 0;
    always @(posedge i_clk) begin
        gnidf_pkg::t_out_item got, want;
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 26);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QuietLimit) begin
            $display("grid_node_inside_domain_filter test failed");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (node_expect_q.size() == 0) begin
                report_mismatch("unexpected result", got.node_x, 32'h0);
            end else begin
                want = node_expect_q.pop_front();
                if (got.node_x !== want.node_x)
                    report_mismatch("node_x", got.node_x, want.node_x);
                if (got.node_y !== want.node_y)
                    report_mismatch("node_y", got.node_y, want.node_y);
                if (got.distance !== want.distance)
                    report_mismatch("distance", got.distance, want.distance);
                if (got.inside_res !== want.inside_res)
                    report_mismatch("inside_res", got.inside_res, want.inside_res);
                if (got.nearest_panel !== want.nearest_panel)
                    report_mismatch("nearest_panel", got.nearest_panel, want.nearest_panel);
                if (got.last_node !== want.last_node)
                    report_mismatch("last_node", got.last_node, want.last_node);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    initial begin
        t_table_row           rows_tab[$];
        t_table_row           row;
        gnidf_pkg::t_out_item blank;
        logic [30:0]          spacings[$];
        gnidf_pkg::t_out_item no_want;

        panels_held = 0;
        box_max_x = '0; box_max_y = '0; box_min_x = '0; box_min_y = '0;
        cols = 0; rows = 0; origin_x = 0; origin_y = 0; walk_col = 0; walk_row = 0;
        walk = WALK_IDLE;
        spacing = gnidf_pkg::SpacingReset;
        no_want = '0;

        // Directed rows: typed expectations where obvious, predictor elsewhere.
        blank = '0;
        blank.status = 1'b1;   // visit with no panels loaded
        row.typed = 1'b1; row.want = blank;
        row.item = visit_item(); rows_tab.push_back(row);
        rows_tab.push_back(row);
        row.typed = 1'b0; row.want = '0;
        row.item = panel_item(32'h0, 32'h0, 32'h0001_0000, 32'h0); rows_tab.push_back(row);
        row.item = visit_item(); rows_tab.push_back(row);
        rows_tab.push_back(row);
        row.item = panel_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        rows_tab.push_back(row);
        row.item = panel_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        rows_tab.push_back(row);
        row.item = visit_item(); rows_tab.push_back(row);
        rows_tab.push_back(row);
        rows_tab.push_back(row);
        row.item = panel_item(32'h7FFF_0000, 32'hFFFF_FFFB, 32'h0, 32'h0); rows_tab.push_back(row);
        row.item = panel_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 32'h0001_0000);
        rows_tab.push_back(row);
        row.item = visit_item(); rows_tab.push_back(row);
        rows_tab.push_back(row);
        rows_tab.push_back(row);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows_tab[i]) send_item(rows_tab[i].item, rows_tab[i].typed, rows_tab[i].want);

        // Random phases, each under its own spacing; extremes among them.
        spacings = '{31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd65536,
                     31'h4000_0000, 31'h7FFF_FFFF, 31'h0100_0000, 31'h7FFF_FFFF,
                     31'd3, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
        foreach (spacings[p]) begin
            drain_and_settle();
            write_spacing((p == 7) ? 31'($urandom) : spacings[p]);
            calm = (p == 4);
            repeat (140) send_item(random_item(), 1'b0, no_want);
        end

        // Fill the panel store; the surplus loads must leave everything alone.
        drain_and_settle();
        calm = 1'b0;
        write_spacing(31'h7FFF_FFFF);
        while (panels_held < PanelDepth)
            send_item(panel_item($urandom, $urandom, $urandom, $urandom), 1'b0, no_want);
        repeat (8) send_item(panel_item($urandom, $urandom, $urandom, $urandom), 1'b0, no_want);
        repeat (20) send_item(visit_item(), 1'b0, no_want);

        drain_and_settle();
        if (mismatches == 0) begin
            $display("grid_node_inside_domain_filter test passed");
        end else begin
            $display("grid_node_inside_domain_filter test failed");
        end
        $finish;
    end
endmodule

FILE: grid_node_inside_domain_filter.f
src/gnidf_pkg.sv
src/gnidf_if.sv
src/gnidf_ctrl.sv
src/gnidf_dpath.sv
src/grid_node_inside_domain_filter.sv
sim/grid_node_inside_domain_filter_tb.sv
